>>> rtl/cmt_pkg.sv
// Package: shared types and constants for the connection map table
`default_nettype none
package cmt_pkg;
   localparam int unsigned Entries = 64;
   localparam int unsigned IdxW = $clog2(Entries);
   localparam logic [15:0] TimeoutReset = 16'd60;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_TICK   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_MISS   = 2'd1,
      ST_FULL   = 2'd2,
      ST_UNUSED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_SCAN,
      SC_WAIT,
      SC_FINISH,
      SC_OUT
   } scan_state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] own_ip;
      logic [31:0] peer_ip;
      logic [23:0] own_qpn;
      logic [23:0] peer_qpn;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] mapped_peer_qpn;
      logic [6:0]  purged_count;
   } rsp_type;
endpackage
`default_nettype wire

>>> rtl/cmt_if.sv
// Interfaces: valid/ready channels for requests and responses
`default_nettype none
interface cmt_req_if;
   logic valid;
   logic ready;
   cmt_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cmt_rsp_if;
   logic valid;
   logic ready;
   cmt_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/cmt_front.sv
// Front end: two-entry request queue between the input channel and the scanner
`default_nettype none
module cmt_front (
   input  wire logic             clock,
   input  wire logic             reset,
   cmt_req_if.sink               req,
   output cmt_pkg::req_type      head_out,
   output logic                  head_valid,
   input  wire logic             head_pop
);
   cmt_pkg::req_type slot_ff [2];
   cmt_pkg::req_type slot_in [2];
   logic             rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push;

   assign req.ready  = (cnt_ff != 2'd2);
   assign push       = req.valid && req.ready;
   assign head_valid = (cnt_ff != 2'd0);
   assign head_out   = slot_ff[rd_ff];

   // queue pointers and storage
   always_comb begin
      slot_in = slot_ff;
      if (push) begin
         slot_in[wr_ff] = req.payload;
      end
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = head_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/cmt_back.sv
// Back end: sequential scan of the table memory for one request at a time
`default_nettype none
module cmt_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [15:0]      timeout,
   input  wire cmt_pkg::req_type head,
   input  wire logic             head_valid,
   output logic                  head_pop,
   cmt_rsp_if.source             rsp
);
   typedef struct packed {
      logic [31:0] lip;
      logic [31:0] rip;
      logic [23:0] lqpn;
      logic [23:0] rqpn;
      logic [31:0] last;
   } row_type;

   // table memory, one write and one read port
   row_type mem [cmt_pkg::Entries];
   row_type rd_ff;
   logic [cmt_pkg::Entries-1:0] valid_ff, valid_in;

   cmt_pkg::scan_state_type state_ff, state_in;
   cmt_pkg::req_type  cur_ff, cur_in;
   logic [cmt_pkg::IdxW-1:0] raddr_ff, raddr_in;
   logic [cmt_pkg::IdxW-1:0] pidx_ff, pidx_in;
   logic [cmt_pkg::IdxW-1:0] hit_ff, hit_in, free_ff, free_in;
   logic hitv_ff, hitv_in, freev_ff, freev_in;
   logic last_ff, last_in;
   logic [31:0] now_ff, now_in;
   logic [6:0]  purged_ff, purged_in;
   cmt_pkg::rsp_type out_ff, out_in;
   logic outv_ff, outv_in;

   logic we;
   logic [cmt_pkg::IdxW-1:0] waddr;
   row_type wdata;
   logic pv, key3, key2, expired;
   logic [31:0] diff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr_ff];
   end

   // compare logic on the registered row
   always_comb begin
      pv   = valid_ff[pidx_ff];
      key3 = pv && rd_ff.lip == cur_ff.own_ip && rd_ff.rip == cur_ff.peer_ip
             && rd_ff.lqpn == cur_ff.own_qpn;
      key2 = pv && rd_ff.lqpn == cur_ff.own_qpn && rd_ff.rip == cur_ff.peer_ip;
      diff = now_ff - rd_ff.last - {16'd0, timeout};
      expired = pv && diff != 32'd0 && !diff[31];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cmt_pkg::SC_IDLE: if (head_valid && !outv_ff) state_in = cmt_pkg::SC_SCAN;
         cmt_pkg::SC_SCAN: state_in = cmt_pkg::SC_WAIT;
         cmt_pkg::SC_WAIT: if (last_ff) state_in = cmt_pkg::SC_FINISH;
         cmt_pkg::SC_FINISH: state_in = cmt_pkg::SC_OUT;
         cmt_pkg::SC_OUT: state_in = cmt_pkg::SC_IDLE;
         default: state_in = cmt_pkg::SC_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cur_in    = cur_ff;
      raddr_in  = raddr_ff;
      pidx_in   = pidx_ff;
      hit_in    = hit_ff;
      hitv_in   = hitv_ff;
      free_in   = free_ff;
      freev_in  = freev_ff;
      last_in   = last_ff;
      now_in    = now_ff;
      purged_in = purged_ff;
      valid_in  = valid_ff;
      out_in    = out_ff;
      outv_in   = outv_ff;
      head_pop  = 1'b0;
      we        = 1'b0;
      waddr     = hit_ff;
      wdata     = rd_ff;
      if (outv_ff && rsp.ready) begin
         outv_in = 1'b0;
      end
      case (state_ff)
         cmt_pkg::SC_IDLE: begin
            if (head_valid && !outv_ff) begin
               head_pop  = 1'b1;
               cur_in    = head;
               raddr_in  = '0;
               hitv_in   = 1'b0;
               freev_in  = 1'b0;
               purged_in = '0;
               last_in   = 1'b0;
               if (head.req_type == cmt_pkg::REQ_TICK) begin
                  now_in = now_ff + 32'd1;
               end
            end
         end
         cmt_pkg::SC_SCAN: begin
            // first read issued; advance address
            pidx_in  = raddr_ff;
            raddr_in = raddr_ff + 1'b1;
         end
         cmt_pkg::SC_WAIT: begin
            // evaluate row pidx_ff
            case (cmt_pkg::req_kind_type'(cur_ff.req_type))
               cmt_pkg::REQ_ADD, cmt_pkg::REQ_LOOKUP: begin
                  if (key3 && !hitv_ff) begin
                     hitv_in = 1'b1;
                     hit_in  = pidx_ff;
                  end
                  if (!pv && !freev_ff) begin
                     freev_in = 1'b1;
                     free_in  = pidx_ff;
                  end
               end
               cmt_pkg::REQ_DELETE: begin
                  if (key2 && !hitv_ff) begin
                     hitv_in = 1'b1;
                     valid_in[pidx_ff] = 1'b0;
                  end
               end
               default: begin
                  if (expired) begin
                     valid_in[pidx_ff] = 1'b0;
                     purged_in = purged_ff + 7'd1;
                  end
               end
            endcase
            // keep the row that hit for a lookup's peer QPN
            if (cur_ff.req_type == cmt_pkg::REQ_LOOKUP && key3 && !hitv_ff) begin
               out_in.mapped_peer_qpn = rd_ff.rqpn;
            end
            last_in = (pidx_ff == cmt_pkg::IdxW'(cmt_pkg::Entries - 1));
            pidx_in  = raddr_ff;
            raddr_in = raddr_ff + 1'b1;
         end
         cmt_pkg::SC_FINISH: begin
            out_in.status = cmt_pkg::ST_OK;
            out_in.purged_count = '0;
            if (cur_ff.req_type != cmt_pkg::REQ_LOOKUP || !hitv_ff) begin
               out_in.mapped_peer_qpn = '0;
            end
            wdata.lip  = cur_ff.own_ip;
            wdata.rip  = cur_ff.peer_ip;
            wdata.lqpn = cur_ff.own_qpn;
            wdata.rqpn = cur_ff.peer_qpn;
            wdata.last = now_ff;
            case (cmt_pkg::req_kind_type'(cur_ff.req_type))
               cmt_pkg::REQ_ADD: begin
                  if (hitv_ff || freev_ff) begin
                     we    = 1'b1;
                     waddr = hitv_ff ? hit_ff : free_ff;
                     valid_in[waddr] = 1'b1;
                  end else begin
                     out_in.status = cmt_pkg::ST_FULL;
                  end
               end
               cmt_pkg::REQ_LOOKUP: begin
                  if (hitv_ff) begin
                     we    = 1'b1;
                     waddr = hit_ff;
                     wdata.rqpn = out_ff.mapped_peer_qpn;
                  end else begin
                     out_in.status = cmt_pkg::ST_MISS;
                  end
               end
               cmt_pkg::REQ_DELETE: begin
                  if (!hitv_ff) out_in.status = cmt_pkg::ST_MISS;
               end
               default: out_in.purged_count = purged_ff;
            endcase
         end
         cmt_pkg::SC_OUT: outv_in = 1'b1;
         default: ;
      endcase
   end

   assign rsp.valid   = outv_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      raddr_ff  <= raddr_in;
      pidx_ff   <= pidx_in;
      hit_ff    <= hit_in;
      free_ff   <= free_in;
      last_ff   <= last_in;
      purged_ff <= purged_in;
      out_ff    <= out_in;
      hitv_ff   <= hitv_in;
      freev_ff  <= freev_in;
      if (reset) begin
         state_ff <= cmt_pkg::SC_IDLE;
         valid_ff <= '0;
         now_ff   <= '0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         now_ff   <= now_in;
         outv_ff  <= outv_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/connection_map_table_with_aging.sv
// Top level: connection map table with idle aging
//
// Requests arrive on req (valid/ready beats of type, local/remote IP,
// local/remote QPN); one response beat per request leaves on rsp with
// status, mapped remote QPN and purge count. csr_we/csr_wdata write the
// 16-bit idle timeout (reset 60 ticks).
// A two-beat front queue decouples the input from the table scanner; an
// accepted beat into an empty queue is at the queue head the next cycle.
// The scanner reads one table row per cycle from its memory. A
// request popped from the queue head goes through pop, first read, a
// compare pass over the table rows, write-back and response load before
// rsp valid. The next request is popped the cycle after the response
// beat is taken, so the scanner works on one request at a time.
// Reset clears all valid bits, the time counter and the queue at once;
// no clearing pass is needed. When rsp is stalled the finished response
// is held, the scanner waits, and the front queue keeps taking up to two
// beats before deasserting ready.
`default_nettype none
module connection_map_table_with_aging (
   input  wire logic        clock,
   input  wire logic        reset,
   cmt_req_if.sink          req,
   cmt_rsp_if.source        rsp,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   logic [15:0] timeout_ff;
   cmt_pkg::req_type head;
   logic head_valid, head_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= cmt_pkg::TimeoutReset;
      end else if (csr_we) begin
         timeout_ff <= csr_wdata;
      end
   end

   cmt_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .head_out(head), .head_valid(head_valid), .head_pop(head_pop)
   );

   cmt_back u_back (
      .clock(clock), .reset(reset), .timeout(timeout_ff),
      .head(head), .head_valid(head_valid), .head_pop(head_pop), .rsp(rsp)
   );
endmodule
`default_nettype wire
